### src/assert_macros.svh
// Assertion macros shared by the encoder counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge out of reset.
`define REC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Property with a same-cycle trigger and a next-cycle consequence.
`define REC_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cons)) else $error(msg);

// Value that never decreases once out of reset.
`define REC_ASSERT_KEEP(label, sig, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        $past(i_rst_n) |-> ((sig) >= $past(sig))) else $error(msg);

`endif

### src/rec_pkg.sv
// Types, constants and helpers of the rotary encoder step counter.
package rec_pkg;

    // Width of the internal hit counters.
    localparam int COUNTER_BITS = 16;
    // Width of the hit fields in the result word.
    localparam int HIT_W        = 16;
    // Common width large enough for both, used for resizing.
    localparam int EXT_W        = (COUNTER_BITS > HIT_W) ? COUNTER_BITS : HIT_W;

    localparam int TIMER_W      = 16;
    localparam int POS_W        = 16;
    localparam int DIR_W        = 2;

    localparam logic [TIMER_W-1:0] DEBOUNCE_RESET = TIMER_W'(5);
    localparam logic [TIMER_W-1:0] TIMER_MAX      = {TIMER_W{1'b1}};
    localparam logic [COUNTER_BITS-1:0] CNT_MAX   = {COUNTER_BITS{1'b1}};

    // Step direction codes.
    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

    typedef logic [COUNTER_BITS-1:0] t_cnt;

    // Input word: one sample of both lines plus the millisecond tick.
    typedef struct packed {
        logic pin_a;
        logic pin_b;
        logic ms_tick;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic [DIR_W-1:0]        step_dir;
        logic [HIT_W-1:0]        debounce_a_hits;
        logic [HIT_W-1:0]        debounce_b_hits;
        logic [HIT_W-1:0]        fail_a_hits;
        logic [HIT_W-1:0]        fail_b_hits;
    } t_out_word;

    // Decoder state carried from word to word.
    typedef struct packed {
        logic               prev_a;
        logic               prev_b;
        logic [TIMER_W-1:0] elapsed_ms;
        logic [POS_W-1:0]   step_count;
        t_cnt               deb_a_count;
        t_cnt               deb_b_count;
        t_cnt               fail_a_count;
        t_cnt               fail_b_count;
    } t_state;

    // Saturating increment of a hit counter.
    function automatic t_cnt sat_inc(input t_cnt v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // Low HIT_W bits of a hit counter, zero-extended when narrower.
    function automatic logic [HIT_W-1:0] to_hits(input t_cnt v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return ext[HIT_W-1:0];
    endfunction

endpackage

### src/rec_step_logic.sv
// Next-state and result logic for one encoder sample.
module rec_step_logic (
    input  rec_pkg::t_state            i_state,
    input  rec_pkg::t_in_word          i_word,
    input  logic [rec_pkg::TIMER_W-1:0] i_debounce_ms,
    output rec_pkg::t_state            o_state,
    output rec_pkg::t_out_word         o_word
);
    import rec_pkg::*;

    logic               fall_a;
    logic               fall_b;
    logic [TIMER_W-1:0] el_tick;
    logic [TIMER_W-1:0] el_after_a;
    logic [DIR_W-1:0]   dir;
    t_state             nxt;

    // Falling edges against the previous sample.
    assign fall_a = i_state.prev_a & ~i_word.pin_a;
    assign fall_b = i_state.prev_b & ~i_word.pin_b;

    // Tick first, saturating at the ceiling.
    assign el_tick = (i_word.ms_tick && (i_state.elapsed_ms != TIMER_MAX))
                   ? i_state.elapsed_ms + 1'b1 : i_state.elapsed_ms;

    always_comb begin
        nxt            = i_state;
        nxt.elapsed_ms = el_tick;
        dir            = DIR_NONE;

        // Line A: handled before line B.
        if (fall_a) begin
            if (!i_word.pin_b) begin
                nxt.fail_a_count = sat_inc(i_state.fail_a_count);
            end else if (el_tick > i_debounce_ms) begin
                nxt.elapsed_ms = '0;
                nxt.step_count = i_state.step_count + 1'b1;
                dir            = DIR_UP;
            end else begin
                nxt.deb_a_count = sat_inc(i_state.deb_a_count);
            end
        end
        el_after_a = nxt.elapsed_ms;

        // Line B sees the timer as line A left it.
        if (fall_b) begin
            if (!i_word.pin_a) begin
                nxt.fail_b_count = sat_inc(i_state.fail_b_count);
            end else if (el_after_a > i_debounce_ms) begin
                nxt.elapsed_ms = '0;
                nxt.step_count = nxt.step_count - 1'b1;
                dir            = DIR_DOWN;
            end else begin
                nxt.deb_b_count = sat_inc(i_state.deb_b_count);
            end
        end

        nxt.prev_a = i_word.pin_a;
        nxt.prev_b = i_word.pin_b;
    end

    assign o_state = nxt;

    // Result word from the updated state.
    always_comb begin
        o_word.position        = $signed(nxt.step_count);
        o_word.step_dir        = dir;
        o_word.debounce_a_hits = to_hits(nxt.deb_a_count);
        o_word.debounce_b_hits = to_hits(nxt.deb_b_count);
        o_word.fail_a_hits     = to_hits(nxt.fail_a_count);
        o_word.fail_b_hits     = to_hits(nxt.fail_b_count);
    end

endmodule

### src/rotary_encoder_debounced_counter_core.sv
// Rotary encoder step counter with debounce and per-line hit statistics.
// Each input word is one sample of encoder lines A and B plus a millisecond
// tick; each accepted word yields exactly one result word carrying the signed
// position, the step taken by this sample and four saturating hit counters.
// The block takes one word per clock: a word passes an input register, then
// the single step of decode logic, and lands in the result register. The decoder
// state updates in that same step, so the word after it sees the updated state.
// Words stop entering only while a result is held and the output side is stalled.
// The debounce_ms register (reset 5) is written through the configuration channel,
// which is always ready; write it only while no word is in flight.
module rotary_encoder_debounced_counter_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input words
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  rec_pkg::t_in_word            i_in_word,
    // result words
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output rec_pkg::t_out_word           o_out_word,
    // debounce_ms register write
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [rec_pkg::TIMER_W-1:0]  i_cfg_data
);
    import rec_pkg::*;
    `include "assert_macros.svh"

    logic               advance;
    logic               r_in_valid;
    t_in_word           r_in_word;
    logic               r_out_valid;
    t_out_word          r_out_word;
    t_state             r_state;
    t_state             n_state;
    t_out_word          n_out_word;
    logic [TIMER_W-1:0] r_debounce_ms;

    // Pipeline moves unless a held result is stalled.
    assign advance    = !(r_out_valid && i_out_stall);
    assign o_in_stall = !advance;
    assign o_cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEBOUNCE_RESET;
        end else if (i_cfg_valid) begin
            r_debounce_ms <= i_cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    // Decode step.
    rec_step_logic u_step (
        .i_state       (r_state),
        .i_word        (r_in_word),
        .i_debounce_ms (r_debounce_ms),
        .o_state       (n_state),
        .o_word        (n_out_word)
    );

    // Decoder state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid          <= 1'b0;
            r_state.prev_a       <= 1'b1;
            r_state.prev_b       <= 1'b1;
            r_state.elapsed_ms   <= '0;
            r_state.step_count   <= '0;
            r_state.deb_a_count  <= '0;
            r_state.deb_b_count  <= '0;
            r_state.fail_a_count <= '0;
            r_state.fail_b_count <= '0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // A word in the input register reaches the result register next clock when the pipeline advances.
    `REC_ASSERT_NEXT(a_word_lands, advance && r_in_valid, r_out_valid, "word lost in decode")
    // A held result always matches the current position.
    `REC_ASSERT(a_pos_match, !r_out_valid || r_out_word.position == r_state.step_count, "stale pos")
    // Fail counters never go backwards.
    `REC_ASSERT_KEEP(a_fail_a_mono, r_state.fail_a_count, "fail_a counter decreased")
    `REC_ASSERT_KEEP(a_fail_b_mono, r_state.fail_b_count, "fail_b counter decreased")

endmodule
